[rtl/encoder_angle_frame_checker_defines.svh]
// Assertion macros shared by the angle frame checker's verification files.
`ifndef ENCODER_ANGLE_FRAME_CHECKER_DEFINES_SVH
`define ENCODER_ANGLE_FRAME_CHECKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EAFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EAFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/eafc_pkg.sv]
// Package with the shared types, constants and CRC matrices of the angle frame checker.
package eafc_pkg;

	// Format codes latched by the back end.
	localparam logic [1:0] FMT_UNKNOWN = 2'd0;
	localparam logic [1:0] FMT_CRC8    = 2'd1;
	localparam logic [1:0] FMT_CRC6    = 2'd2;

	// CRC polynomials, both with a zero initial value and no final XOR.
	localparam logic [7:0] CRC8_POLY = 8'h07;
	localparam logic [5:0] CRC6_POLY = 6'h03;

	// Bits covered by each check.
	localparam int CRC8_DATA_W = 24;
	localparam int CRC6_DATA_W = 18;

	// Default depth of the queue between front and back end.
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	typedef logic [7:0][CRC8_DATA_W-1:0] crc8_mat_t;
	typedef logic [5:0][CRC6_DATA_W-1:0] crc6_mat_t;

	// Classification of one frame, handed from the front end to the back end.
	typedef struct packed {
		logic [20:0] angle8;
		logic [2:0]  status8;
		logic        ok8;
		logic [13:0] angle6;
		logic [3:0]  status6;
		logic        ok6;
	} eafc_cls_t;

	// Bit-serial CRC-8, MSB first; used only to build the matrix below.
	function automatic logic [7:0] crc8_serial(input logic [CRC8_DATA_W-1:0] w);
		logic [7:0] r;
		logic       top;
		r = '0;
		for (int i = CRC8_DATA_W - 1; i >= 0; i--) begin
			top = r[7] ^ w[i];
			r   = {r[6:0], 1'b0};
			if (top) begin
				r = r ^ CRC8_POLY;
			end
		end
		return r;
	endfunction

	// Bit-serial CRC-6, MSB first; used only to build the matrix below.
	function automatic logic [5:0] crc6_serial(input logic [CRC6_DATA_W-1:0] w);
		logic [5:0] r;
		logic       top;
		r = '0;
		for (int i = CRC6_DATA_W - 1; i >= 0; i--) begin
			top = r[5] ^ w[i];
			r   = {r[4:0], 1'b0};
			if (top) begin
				r = r ^ CRC6_POLY;
			end
		end
		return r;
	endfunction

	// Row i holds the data bits whose XOR gives CRC bit i.
	function automatic crc8_mat_t crc8_matrix();
		crc8_mat_t                m;
		logic [7:0]               r;
		logic [CRC8_DATA_W-1:0]   unit;
		m = '0;
		for (int j = 0; j < CRC8_DATA_W; j++) begin
			unit = CRC8_DATA_W'(1) << j;
			r    = crc8_serial(unit);
			for (int i = 0; i < 8; i++) begin
				m[i][j] = r[i];
			end
		end
		return m;
	endfunction

	function automatic crc6_mat_t crc6_matrix();
		crc6_mat_t                m;
		logic [5:0]               r;
		logic [CRC6_DATA_W-1:0]   unit;
		m = '0;
		for (int j = 0; j < CRC6_DATA_W; j++) begin
			unit = CRC6_DATA_W'(1) << j;
			r    = crc6_serial(unit);
			for (int i = 0; i < 6; i++) begin
				m[i][j] = r[i];
			end
		end
		return m;
	endfunction

	localparam crc8_mat_t CRC8_MAT = crc8_matrix();
	localparam crc6_mat_t CRC6_MAT = crc6_matrix();

endpackage

[rtl/eafc_front.sv]
// Front end: realigns the received bytes and checks both frame formats.
module eafc_front import eafc_pkg::*; (
	input  logic [7:0] rx_byte0,
	input  logic [7:0] rx_byte1,
	input  logic [7:0] rx_byte2,
	input  logic [7:0] rx_byte3,
	input  logic [7:0] rx_byte4,
	output eafc_cls_t  cls
);

	logic [7:0]             d0, d1, d2, d3;
	logic [CRC8_DATA_W-1:0] data8;
	logic [CRC6_DATA_W-1:0] data6;
	logic [7:0]             crc8;
	logic [5:0]             crc6;

	// The stream arrived one bit late, so shift it left by one bit.
	assign d0 = {rx_byte0[6:0], rx_byte1[7]};
	assign d1 = {rx_byte1[6:0], rx_byte2[7]};
	assign d2 = {rx_byte2[6:0], rx_byte3[7]};
	assign d3 = {rx_byte3[6:0], rx_byte4[7]};

	assign data8 = {d0, d1, d2};
	assign data6 = {d0, d1, d2[7:6]};

	// Each CRC bit is an XOR of a fixed set of data bits.
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			crc8[i] = ^(data8 & CRC8_MAT[i]);
		end
		for (int i = 0; i < 6; i++) begin
			crc6[i] = ^(data6 & CRC6_MAT[i]);
		end
	end

	// Candidate results of both formats.
	assign cls.angle8  = {d0, d1, d2[7:3]};
	assign cls.status8 = d2[2:0];
	assign cls.ok8     = (crc8 == d3);
	assign cls.angle6  = {d0, d1[7:2]};
	assign cls.status6 = {d1[1:0], d2[7:6]};
	assign cls.ok6     = (crc6 == d2[5:0]);

endmodule

[rtl/eafc_queue.sv]
// Short first-in first-out queue that decouples the front end from the back end.
module eafc_queue import eafc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  eafc_cls_t wr_data,
	output logic      full,
	input  logic      rd_en,
	output eafc_cls_t rd_data,
	output logic      empty
);

	// DEPTH is a power of two of at least two, so the pointers wrap by themselves.
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	eafc_cls_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Storage is written on every transfer into the queue.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[rtl/eafc_back.sv]
// Back end: applies the format decision, keeps the held state and registers the result.
module eafc_back import eafc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  eafc_cls_t   cls,
	input  logic        cls_empty,
	output logic        cls_pop,
	output logic        empty,
	input  logic        pop,
	output logic [20:0] angle_out,
	output logic [3:0]  status_out,
	output logic        frame_ok,
	output logic [1:0]  format_found,
	output logic [31:0] error_total
);

	logic [1:0]  format_q;
	logic [20:0] held_angle_q;
	logic [3:0]  held_status_q;
	logic [31:0] fail_count_q;
	logic        out_valid_q;

	logic        pass8, pass6, ok;
	logic [1:0]  format_nxt;
	logic [20:0] angle_nxt;
	logic [3:0]  status_nxt;
	logic [31:0] fail_nxt;

	// Take a frame whenever the result register is free or is being emptied.
	assign cls_pop = !cls_empty && (!out_valid_q || pop);
	assign empty   = !out_valid_q;

	// CRC-8 format wins when both pass; once a format is latched, only that format is tried.
	assign pass8 = cls.ok8 && (format_q == FMT_UNKNOWN || format_q == FMT_CRC8);
	assign pass6 = !pass8 && cls.ok6 && (format_q == FMT_UNKNOWN || format_q == FMT_CRC6);
	assign ok    = pass8 || pass6;

	always_comb begin
		format_nxt = format_q;
		angle_nxt  = held_angle_q;
		status_nxt = held_status_q;
		fail_nxt   = fail_count_q;
		priority if (pass8) begin
			format_nxt = FMT_CRC8;
			angle_nxt  = cls.angle8;
			status_nxt = {1'b0, cls.status8};
		end else if (pass6) begin
			format_nxt = FMT_CRC6;
			angle_nxt  = {cls.angle6, 7'd0};
			status_nxt = cls.status6;
		end else if (fail_count_q != '1) begin
			// The error count saturates rather than wrapping.
			fail_nxt = fail_count_q + 32'd1;
		end
	end

	// Held state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q      <= FMT_UNKNOWN;
			held_angle_q  <= '0;
			held_status_q <= '0;
			fail_count_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cls_pop) begin
				format_q      <= format_nxt;
				held_angle_q  <= angle_nxt;
				held_status_q <= status_nxt;
				fail_count_q  <= fail_nxt;
				out_valid_q   <= 1'b1;
			end else if (pop) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cls_pop) begin
			frame_ok <= ok;
		end
	end

	assign angle_out    = held_angle_q;
	assign status_out   = held_status_q;
	assign format_found = format_q;
	assign error_total  = fail_count_q;

endmodule

[rtl/encoder_angle_frame_checker.sv]
// Top level of the angle frame checker: front end, decoupling queue and back end.
//
// Channel   Direction  Transfer when     Payload
// input     in         push && !full     rx_byte0 .. rx_byte4
// result    out        pop && !empty     angle_out, status_out, frame_ok,
//                                        format_found, error_total
//
// One frame is accepted per cycle while full is low, and one result is delivered per
// cycle while empty is low. A frame is checked in the cycle it is accepted and written
// into the queue; it leaves the queue once the result register is free or is being
// emptied, which loads its result onto the result ports. The queue holds QUEUE_DEPTH
// frames beside the result register, and full rises when a stalled result side has
// filled it. Reset clears the format, held values, error count, queue and result.
module encoder_angle_frame_checker import eafc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte0,
	input  logic [7:0]  rx_byte1,
	input  logic [7:0]  rx_byte2,
	input  logic [7:0]  rx_byte3,
	input  logic [7:0]  rx_byte4,
	output logic        empty,
	input  logic        pop,
	output logic [20:0] angle_out,
	output logic [3:0]  status_out,
	output logic        frame_ok,
	output logic [1:0]  format_found,
	output logic [31:0] error_total
);

	eafc_cls_t front_cls;
	eafc_cls_t queue_cls;
	logic      queue_empty;
	logic      queue_pop;

	// Frame realignment and CRC checks.
	eafc_front u_front (
		.rx_byte0 (rx_byte0),
		.rx_byte1 (rx_byte1),
		.rx_byte2 (rx_byte2),
		.rx_byte3 (rx_byte3),
		.rx_byte4 (rx_byte4),
		.cls      (front_cls)
	);

	// Queue between the two halves.
	eafc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && !full),
		.wr_data (front_cls),
		.full    (full),
		.rd_en   (queue_pop),
		.rd_data (queue_cls),
		.empty   (queue_empty)
	);

	// Format decision, held state and result register.
	eafc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cls          (queue_cls),
		.cls_empty    (queue_empty),
		.cls_pop      (queue_pop),
		.empty        (empty),
		.pop          (pop),
		.angle_out    (angle_out),
		.status_out   (status_out),
		.frame_ok     (frame_ok),
		.format_found (format_found),
		.error_total  (error_total)
	);

endmodule

[rtl/eafc_checker.sv]
// Port-level assertions for the angle frame checker and the bind that attaches them.
`include "encoder_angle_frame_checker_defines.svh"

module eafc_checker import eafc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [20:0] angle_out,
	input logic [3:0]  status_out,
	input logic        frame_ok,
	input logic [1:0]  format_found,
	input logic [31:0] error_total
);

	// A passing frame always leaves a latched format behind.
	`EAFC_ASSERT_NOW(a_ok_has_format, !empty && frame_ok,
		format_found != FMT_UNKNOWN, "frame passed with no format latched")

	// While no format is known, no frame has passed, so the held values are still zero.
	`EAFC_ASSERT_NOW(a_unknown_holds_zero, !empty && format_found == FMT_UNKNOWN,
		angle_out == '0 && status_out == '0, "held values changed before any frame passed")

	// A waiting result is not withdrawn.
	`EAFC_ASSERT_NEXT(a_result_stays, !empty && !pop, !empty, "result withdrawn while waiting")

	// A waiting result keeps its error count and angle.
	`EAFC_ASSERT_NEXT(a_result_stable, !empty && !pop,
		$stable(error_total) && $stable(angle_out), "result changed while waiting")

endmodule

bind encoder_angle_frame_checker eafc_checker u_eafc_checker (.*);

[bench/encoder_angle_frame_checker_tb.sv]
`timescale 1ns / 100ps
// Testbench for the angle frame checker: a queued driver, a result monitor and a frame predictor.
module encoder_angle_frame_checker_tb;
	import eafc_pkg::*;

	localparam int RANDOM_FRAMES = 1900;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 20;

	// One five-byte transfer as received, before realignment.
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] b4;
	} rx_frame_t;

	// The fields of one result, at the widths of the result ports.
	typedef struct packed {
		logic [20:0] angle;
		logic [3:0]  status;
		logic        ok;
		logic [1:0]  fmt;
		logic [31:0] errors;
	} angle_result_t;

	// Receiver behaviour, chosen anew at random intervals.
	typedef enum logic [1:0] {
		RX_ALWAYS_READY,
		RX_COIN_FLIP,
		RX_LONG_STALLS
	} rx_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic [7:0]  rx_byte0 = 8'h00;
	logic [7:0]  rx_byte1 = 8'h00;
	logic [7:0]  rx_byte2 = 8'h00;
	logic [7:0]  rx_byte3 = 8'h00;
	logic [7:0]  rx_byte4 = 8'h00;
	logic        full;
	logic        empty;
	logic [20:0] angle_out;
	logic [3:0]  status_out;
	logic        frame_ok;
	logic [1:0]  format_found;
	logic [31:0] error_total;

	// Predicted state of the block.
	logic [1:0]  seen_fmt = FMT_UNKNOWN;
	logic [20:0] good_angle = '0;
	logic [3:0]  good_status = '0;
	logic [31:0] crc_failures = '0;

	rx_frame_t     frames_to_send[$];
	angle_result_t results_due[$];

	int       mismatches = 0;
	int       cycles = 0;
	bit       in_took = 1'b0;
	int       gap_left = 0;
	int       burst_left = 0;
	int       stall_left = 0;
	int       mode_age = 0;
	rx_mode_e rx_mode = RX_ALWAYS_READY;

	encoder_angle_frame_checker u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.rx_byte0     (rx_byte0),
		.rx_byte1     (rx_byte1),
		.rx_byte2     (rx_byte2),
		.rx_byte3     (rx_byte3),
		.rx_byte4     (rx_byte4),
		.empty        (empty),
		.pop          (pop),
		.angle_out    (angle_out),
		.status_out   (status_out),
		.frame_ok     (frame_ok),
		.format_found (format_found),
		.error_total  (error_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// CRC-8 over three bytes, MSB first, zero initial value.
	function automatic logic [7:0] crc8_of(input logic [23:0] data);
		logic [7:0] rem;
		rem = '0;
		for (int i = 23; i >= 0; i--) begin
			if (rem[7] ^ data[i]) begin
				rem = {rem[6:0], 1'b0} ^ CRC8_POLY;
			end else begin
				rem = {rem[6:0], 1'b0};
			end
		end
		return rem;
	endfunction

	// CRC-6 over the 14-bit angle and 4 status bits, MSB first, zero initial value.
	function automatic logic [5:0] crc6_of(input logic [17:0] data);
		logic [5:0] rem;
		rem = '0;
		for (int i = 17; i >= 0; i--) begin
			if (rem[5] ^ data[i]) begin
				rem = {rem[4:0], 1'b0} ^ CRC6_POLY;
			end else begin
				rem = {rem[4:0], 1'b0};
			end
		end
		return rem;
	endfunction

	// Builds a frame from four realigned bytes, choosing which of the two checks it passes.
	// The discarded top bit of the first byte and the unused bits of the last are random.
	function automatic rx_frame_t seal_frame(input logic [31:0] d, input bit crc8_good,
			input bit crc6_good);
		logic [5:0]  c6;
		logic [7:0]  c8;
		logic [39:0] raw;
		c6 = crc6_of(d[31:14]);
		if (crc6_good) begin
			d[13:8] = c6;
		end else if (d[13:8] == c6) begin
			d[13:8] = c6 ^ 6'h01;
		end
		c8 = crc8_of(d[31:8]);
		if (crc8_good) begin
			d[7:0] = c8;
		end else if (d[7:0] == c8) begin
			d[7:0] = c8 ^ 8'h01;
		end
		raw = 40'({$urandom, $urandom});
		raw[38:7] = d;
		return rx_frame_t'(raw);
	endfunction

	// Works out the result of one frame and advances the predicted state.
	task automatic judge_frame(input rx_frame_t f, output angle_result_t r);
		logic [39:0] raw;
		logic [31:0] d;
		logic        hit;
		raw = f;
		d   = raw[38:7];
		hit = 1'b0;
		// Wide format: 21-bit angle, 3 status bits, CRC-8 in the last byte.
		if ((seen_fmt == FMT_UNKNOWN || seen_fmt == FMT_CRC8) && crc8_of(d[31:8]) == d[7:0]) begin
			good_angle  = d[31:11];
			good_status = {1'b0, d[10:8]};
			seen_fmt    = FMT_CRC8;
			hit         = 1'b1;
		end
		// Narrow format: 14-bit angle, 4 status bits, CRC-6 in the low bits of the third byte.
		if (!hit && (seen_fmt == FMT_UNKNOWN || seen_fmt == FMT_CRC6)
				&& crc6_of(d[31:14]) == d[13:8]) begin
			good_angle  = {d[31:18], 7'd0};
			good_status = d[17:14];
			seen_fmt    = FMT_CRC6;
			hit         = 1'b1;
		end
		// The failure count saturates rather than wrapping.
		if (!hit && crc_failures != 32'hFFFF_FFFF) begin
			crc_failures = crc_failures + 32'd1;
		end
		r.angle  = good_angle;
		r.status = good_status;
		r.ok     = hit;
		r.fmt    = seen_fmt;
		r.errors = crc_failures;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (act !== exp) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			mismatches++;
		end
	endtask

	// Monitor: records accepted frames and checks each result transfer against the oldest
	// prediction.
	always @(posedge clk) begin
		angle_result_t want;
		in_took = arst_n && push && !full;
		if (in_took) begin
			judge_frame({rx_byte0, rx_byte1, rx_byte2, rx_byte3, rx_byte4}, want);
			results_due.push_back(want);
		end
		if (arst_n && pop && !empty) begin
			if (results_due.size() == 0) begin
				$error("result transfer with no frame outstanding");
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("angle_out", 32'(want.angle), 32'(angle_out));
				check_field("status_out", 32'(want.status), 32'(status_out));
				check_field("frame_ok", 32'(want.ok), 32'(frame_ok));
				check_field("format_found", 32'(want.fmt), 32'(format_found));
				check_field("error_total", want.errors, error_total);
			end
		end
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** encoder_angle_frame_checker: FAILED **");
			$finish;
		end
	end

	// Driver: sends queued frames in bursts with random gaps, and drives noise while idle.
	always @(negedge clk) begin
		rx_frame_t f;
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || in_took) begin
			if (gap_left > 0 || frames_to_send.size() == 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end
				push <= 1'b0;
				{rx_byte0, rx_byte1, rx_byte2, rx_byte3, rx_byte4} <= 40'({$urandom, $urandom});
			end else begin
				f = frames_to_send.pop_front();
				{rx_byte0, rx_byte1, rx_byte2, rx_byte3, rx_byte4} <= f;
				push <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// Receiver: pop follows a mode that changes now and then; long stalls fill the queue.
	always @(negedge clk) begin
		if (mode_age == 0) begin
			rx_mode  = rx_mode_e'($urandom_range(0, 2));
			mode_age = $urandom_range(100, 300);
		end else begin
			mode_age--;
		end
		if (stall_left > 0) begin
			stall_left--;
			pop <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS_READY: begin
					pop <= 1'b1;
				end
				RX_COIN_FLIP: begin
					pop <= 1'($urandom_range(0, 1));
				end
				default: begin
					pop <= 1'b1;
					if ($urandom_range(0, 19) == 0) begin
						stall_left = $urandom_range(10, 40);
					end
				end
			endcase
		end
	end

	// Stimulus and end of run.
	initial begin
		bit          home_crc6;
		int          pick;
		logic [39:0] raw;
		// The format stays latched until reset, so each run settles on one home format.
		home_crc6 = 1'($urandom_range(0, 1));

		// Frames that fail both checks while the format is still unknown.
		frames_to_send.push_back(seal_frame($urandom, 1'b0, 1'b0));
		frames_to_send.push_back(seal_frame(32'hFFFF_FFFF, 1'b0, 1'b0));
		// The frame that latches the format; passing both checks must pick the wide format.
		if (home_crc6) begin
			frames_to_send.push_back(seal_frame($urandom, 1'b0, 1'b1));
		end else begin
			frames_to_send.push_back(seal_frame($urandom, 1'b1, 1'b1));
		end
		// Extremes of the byte fields, including the discarded and unused bits.
		frames_to_send.push_back(40'h00_00_00_00_00);
		frames_to_send.push_back(40'hFF_FF_FF_FF_FF);
		frames_to_send.push_back(40'h80_00_00_00_00);
		frames_to_send.push_back(40'h00_00_00_00_7F);
		frames_to_send.push_back(40'h55_AA_55_AA_55);
		frames_to_send.push_back(40'hAA_55_AA_55_AA);
		// Largest and smallest angles, each under three of the four combinations of the two checks.
		frames_to_send.push_back(seal_frame(32'hFFFF_FFFF, 1'b1, 1'b1));
		frames_to_send.push_back(seal_frame(32'hFFFF_FFFF, 1'b1, 1'b0));
		frames_to_send.push_back(seal_frame(32'hFFFF_FFFF, 1'b0, 1'b1));
		frames_to_send.push_back(seal_frame(32'h0000_0000, 1'b0, 1'b0));
		frames_to_send.push_back(seal_frame(32'h0000_0000, 1'b1, 1'b0));
		frames_to_send.push_back(seal_frame(32'h0000_0000, 1'b0, 1'b1));
		frames_to_send.push_back(seal_frame(32'h8000_0000, 1'b1, 1'b1));
		// Failed frames after latching must return the held angle and status; then one passing both.
		frames_to_send.push_back(seal_frame($urandom, 1'b0, 1'b0));
		frames_to_send.push_back(seal_frame($urandom, 1'b0, 1'b0));
		frames_to_send.push_back(seal_frame($urandom, 1'b1, 1'b1));

		// Mostly good frames in the home format, some in the other, some corrupted, some noise.
		for (int n = 0; n < RANDOM_FRAMES; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				if (home_crc6) begin
					frames_to_send.push_back(seal_frame($urandom, 1'($urandom_range(0, 1)), 1'b1));
				end else begin
					frames_to_send.push_back(seal_frame($urandom, 1'b1, 1'($urandom_range(0, 1))));
				end
			end else if (pick < 65) begin
				frames_to_send.push_back(seal_frame($urandom, home_crc6, !home_crc6));
			end else if (pick < 82) begin
				raw = seal_frame($urandom, !home_crc6, home_crc6);
				raw[$urandom_range(0, 39)] ^= 1'b1;
				frames_to_send.push_back(rx_frame_t'(raw));
			end else begin
				raw = 40'({$urandom, $urandom});
				frames_to_send.push_back(rx_frame_t'(raw));
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every frame to be sent and every result to be checked.
		@(negedge clk);
		while (frames_to_send.size() != 0 || push) begin
			@(negedge clk);
		end
		while (results_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && results_due.size() == 0) begin
			$display("** encoder_angle_frame_checker: PASSED **");
		end else begin
			$display("** encoder_angle_frame_checker: FAILED **");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/eafc_pkg.sv
rtl/eafc_front.sv
rtl/eafc_queue.sv
rtl/eafc_back.sv
rtl/encoder_angle_frame_checker.sv
rtl/eafc_checker.sv
bench/encoder_angle_frame_checker_tb.sv
